>>> sv/uwt_pkg.sv
package uwt_pkg;

  // Result slots per input byte and field widths
  localparam int UNITS = 4;
  localparam int HELD  = 3;
  localparam int CP_W  = 21;
  localparam int NB_W  = 3;

  // Byte class masks and tags
  localparam logic [7:0] CONT_MASK  = 8'hC0;
  localparam logic [7:0] CONT_TAG   = 8'h80;
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_TAG  = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_TAG  = 8'hE0;
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_TAG  = 8'hF0;

  // Sequence lengths
  localparam logic [NB_W-1:0] LEN1 = 3'd1;
  localparam logic [NB_W-1:0] LEN2 = 3'd2;
  localparam logic [NB_W-1:0] LEN3 = 3'd3;
  localparam logic [NB_W-1:0] LEN4 = 3'd4;

  // Whitespace code points above the ASCII range: isolated ones, then the bounds of one range
  localparam logic [CP_W-1:0] CP_NEL    = 21'h00085;
  localparam logic [CP_W-1:0] CP_NBSP   = 21'h000A0;
  localparam logic [CP_W-1:0] CP_OGHAM  = 21'h01680;
  localparam logic [CP_W-1:0] CP_LSEP   = 21'h02028;
  localparam logic [CP_W-1:0] CP_PSEP   = 21'h02029;
  localparam logic [CP_W-1:0] CP_NNBSP  = 21'h0202F;
  localparam logic [CP_W-1:0] CP_MMSP   = 21'h0205F;
  localparam logic [CP_W-1:0] CP_IDSP   = 21'h03000;
  localparam logic [CP_W-1:0] CP_SP_LO  = 21'h02000;
  localparam logic [CP_W-1:0] CP_SP_HI  = 21'h0200A;

  typedef struct packed {
    logic [CP_W-1:0] cp;
    logic [NB_W-1:0] nb;
    logic            raw;
  } uwt_unit_t;

  // Units caused by one input byte, in emission order
  typedef struct packed {
    uwt_unit_t [UNITS-1:0] unit;
    logic [NB_W-1:0]       cnt;
    logic                  fin;
  } uwt_batch_t;

  // Whitespace test of Python str.isspace()
  function automatic logic ws_class(input logic [CP_W-1:0] cp);
    logic sp;
    sp = 1'b0;
    if (cp < 21'h80) begin
      sp = (cp >= 21'h09 && cp <= 21'h0D) || (cp >= 21'h1C && cp <= 21'h20);
    end else begin
      sp = (cp == CP_NEL) || (cp == CP_NBSP) || (cp == CP_OGHAM) ||
           (cp == CP_LSEP) || (cp == CP_PSEP) || (cp == CP_NNBSP) ||
           (cp == CP_MMSP) || (cp == CP_IDSP) ||
           (cp >= CP_SP_LO && cp <= CP_SP_HI);
    end
    return sp;
  endfunction

endpackage

>>> sv/uwt_if.sv
interface uwt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

interface uwt_out_if;
  logic        valid;
  logic        ready;
  logic [20:0] code_point;
  logic [2:0]  unit_bytes;
  logic        is_space;
  logic        word_start;
  logic        raw_fallback;
  logic        text_end;
  logic        run_last;

  modport source (output valid, output code_point, output unit_bytes, output is_space,
                  output word_start, output raw_fallback, output text_end,
                  output run_last, input ready);
  modport sink   (input valid, input code_point, input unit_bytes, input is_space,
                  input word_start, input raw_fallback, input text_end,
                  input run_last, output ready);
endinterface

>>> sv/uwt_decode.sv
module uwt_decode (
  input  logic                clk,
  input  logic                rst_n,
  uwt_in_if.sink              in_chan,
  output logic                batch_v,
  output uwt_pkg::uwt_batch_t batch,
  input  logic                batch_take
);

  logic [7:0]                  held_r [uwt_pkg::HELD];
  logic [1:0]                  held_cnt_r, held_cnt_nxt;
  logic [uwt_pkg::NB_W-1:0]    exp_len_r, exp_len_nxt;
  logic [uwt_pkg::CP_W-1:0]    pp_r, pp_nxt;
  logic                        batch_v_r, batch_v_nxt;
  uwt_pkg::uwt_batch_t         batch_r, batch_nxt;

  logic [7:0]                  b;
  logic                        fin, acc, cont, is_ascii, is_lead;
  logic [uwt_pkg::NB_W-1:0]    new_cnt, lead_len;
  logic [uwt_pkg::CP_W-1:0]    new_pp, lead_pp;
  logic [1:0]                  pre_n, hw_idx;
  logic                        tail_v, hw_en;
  uwt_pkg::uwt_unit_t          tail;

  assign b        = in_chan.data_byte;
  assign fin      = in_chan.final_byte;
  assign in_chan.ready = !batch_v_r || batch_take;
  assign acc      = in_chan.valid && in_chan.ready;

  // Classify the incoming byte
  assign cont     = (b & uwt_pkg::CONT_MASK) == uwt_pkg::CONT_TAG;
  assign is_ascii = !b[7];
  assign new_cnt  = {1'b0, held_cnt_r} + 3'd1;
  assign new_pp   = {pp_r[uwt_pkg::CP_W-7:0], b[5:0]};

  always_comb begin
    lead_len = uwt_pkg::LEN1;
    lead_pp  = '0;
    is_lead  = 1'b1;
    if ((b & uwt_pkg::LEAD2_MASK) == uwt_pkg::LEAD2_TAG) begin
      lead_len = uwt_pkg::LEN2;
      lead_pp  = {16'b0, b[4:0]};
    end else if ((b & uwt_pkg::LEAD3_MASK) == uwt_pkg::LEAD3_TAG) begin
      lead_len = uwt_pkg::LEN3;
      lead_pp  = {17'b0, b[3:0]};
    end else if ((b & uwt_pkg::LEAD4_MASK) == uwt_pkg::LEAD4_TAG) begin
      lead_len = uwt_pkg::LEN4;
      lead_pp  = {18'b0, b[2:0]};
    end else begin
      is_lead  = 1'b0;
    end
  end

  // Decide the units for this byte: held raw bytes first, then at most one tail unit
  always_comb begin
    pre_n        = 2'd0;
    tail_v       = 1'b0;
    tail.cp      = {13'b0, b};
    tail.nb      = uwt_pkg::LEN1;
    tail.raw     = 1'b1;
    held_cnt_nxt = held_cnt_r;
    exp_len_nxt  = exp_len_r;
    pp_nxt       = pp_r;
    hw_en        = 1'b0;
    hw_idx       = held_cnt_r;
    if (held_cnt_r != 2'd0 && cont) begin
      if (new_cnt >= exp_len_r) begin
        // sequence complete
        tail_v       = 1'b1;
        tail.cp      = new_pp;
        tail.nb      = exp_len_r;
        tail.raw     = 1'b0;
        held_cnt_nxt = 2'd0;
        exp_len_nxt  = '0;
        pp_nxt       = '0;
      end else if (fin) begin
        // truncated at end of text: flush held bytes and this one raw
        pre_n        = held_cnt_r;
        tail_v       = 1'b1;
        held_cnt_nxt = 2'd0;
        exp_len_nxt  = '0;
        pp_nxt       = '0;
      end else begin
        hw_en        = 1'b1;
        held_cnt_nxt = new_cnt[1:0];
        pp_nxt       = new_pp;
      end
    end else begin
      // flush whatever is held, then take the byte fresh
      pre_n        = held_cnt_r;
      held_cnt_nxt = 2'd0;
      exp_len_nxt  = '0;
      pp_nxt       = '0;
      if (is_ascii) begin
        tail_v   = 1'b1;
        tail.raw = 1'b0;
      end else if (is_lead && !fin) begin
        hw_en        = 1'b1;
        hw_idx       = 2'd0;
        held_cnt_nxt = 2'd1;
        exp_len_nxt  = lead_len;
        pp_nxt       = lead_pp;
      end else begin
        tail_v = 1'b1;
      end
    end
  end

  // Assemble the batch
  always_comb begin
    for (int k = 0; k < uwt_pkg::HELD; k++) begin
      if (2'(k) < pre_n) begin
        batch_nxt.unit[k].cp  = {13'b0, held_r[k]};
        batch_nxt.unit[k].nb  = uwt_pkg::LEN1;
        batch_nxt.unit[k].raw = 1'b1;
      end else begin
        batch_nxt.unit[k] = tail;
      end
    end
    batch_nxt.unit[uwt_pkg::UNITS-1] = tail;
    batch_nxt.cnt = {1'b0, pre_n} + {2'b0, tail_v};
    batch_nxt.fin = fin;
  end

  always_comb begin
    batch_v_nxt = batch_v_r && !batch_take;
    if (acc && batch_nxt.cnt != '0) begin
      batch_v_nxt = 1'b1;
    end
  end

  // Hold sequence state and the batch register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_cnt_r <= 2'd0;
      exp_len_r  <= '0;
      pp_r       <= '0;
      batch_v_r  <= 1'b0;
    end else begin
      batch_v_r <= batch_v_nxt;
      if (acc) begin
        held_cnt_r <= held_cnt_nxt;
        exp_len_r  <= exp_len_nxt;
        pp_r       <= pp_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc && hw_en && hw_idx != 2'd3) begin
      held_r[hw_idx] <= b;
    end
    if (acc && batch_nxt.cnt != '0) begin
      batch_r <= batch_nxt;
    end
  end

  assign batch_v = batch_v_r;
  assign batch   = batch_r;

  // Sequence bookkeeping stays consistent
  a_len_above_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    held_cnt_r != 2'd0 |-> exp_len_r > {1'b0, held_cnt_r})
    else $error("held count not below expected length");

  a_idle_len: assert property (@(posedge clk) disable iff (!rst_n)
    held_cnt_r == 2'd0 |-> exp_len_r == '0)
    else $error("expected length set with nothing held");

  a_fin_clears: assert property (@(posedge clk) disable iff (!rst_n)
    acc && fin |=> held_cnt_r == 2'd0)
    else $error("sequence left open after final byte");

  a_batch_hold: assert property (@(posedge clk) disable iff (!rst_n)
    batch_v_r && !batch_take |=> batch_v_r && $stable(batch_r))
    else $error("pending batch changed before it was drained");

endmodule

>>> sv/uwt_emit.sv
module uwt_emit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                batch_v,
  input  uwt_pkg::uwt_batch_t batch,
  output logic                batch_take,
  uwt_out_if.source           out_chan
);

  logic [1:0]               idx_r, idx_nxt;
  logic                     as_r, as_nxt;
  logic                     out_v_r;
  logic [uwt_pkg::CP_W-1:0] cp_r;
  logic [uwt_pkg::NB_W-1:0] nb_r;
  logic                     sp_r, ws_r, raw_r, end_r, last_r;

  uwt_pkg::uwt_unit_t       cur;
  logic                     load, last, sp, tend;

  // Pick the current unit of the batch and class it
  assign cur  = batch.unit[idx_r];
  assign last = {1'b0, idx_r} == (batch.cnt - 3'd1);
  assign load = batch_v && (!out_v_r || out_chan.ready);
  assign sp   = uwt_pkg::ws_class(cur.cp);
  assign tend = last && batch.fin;
  assign batch_take = load && last;

  always_comb begin
    idx_nxt = idx_r;
    as_nxt  = as_r;
    if (load) begin
      idx_nxt = last ? 2'd0 : idx_r + 2'd1;
      as_nxt  = tend ? 1'b1 : sp;
    end
  end

  // Advance through the batch and hold the word state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= 2'd0;
      as_r    <= 1'b1;
      out_v_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      as_r  <= as_nxt;
      if (load) begin
        out_v_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (load) begin
      cp_r   <= cur.cp;
      nb_r   <= cur.nb;
      raw_r  <= cur.raw;
      sp_r   <= sp;
      ws_r   <= !sp && as_r;
      end_r  <= tend;
      last_r <= last;
    end
  end

  assign out_chan.valid        = out_v_r;
  assign out_chan.code_point   = cp_r;
  assign out_chan.unit_bytes   = nb_r;
  assign out_chan.is_space     = sp_r;
  assign out_chan.word_start   = ws_r;
  assign out_chan.raw_fallback = raw_r;
  assign out_chan.text_end     = end_r;
  assign out_chan.run_last     = last_r;

  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && end_r |-> last_r)
    else $error("text end on a result that is not the last of its byte");

  a_word_not_space: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && ws_r |-> !sp_r)
    else $error("word start on a whitespace unit");

  a_text_restart: assert property (@(posedge clk) disable iff (!rst_n)
    load && tend |=> as_r)
    else $error("word state not back to text start after final unit");

endmodule

>>> sv/utf8_whitespace_tokenizer.sv
// UTF-8 whitespace tokenizer. Takes text one byte per transaction, final_byte
// set on the last byte, and returns one result per decoded unit: the code point
// (or the raw byte of a broken or truncated sequence), its byte count, whether
// it is Python-style whitespace and whether it starts a word. A byte that
// completes a character, or an ASCII/stray byte, gives one result; a byte that
// only extends a sequence gives none; a byte that breaks a sequence gives up to
// four. Input bytes are taken one per cycle while each gives at most one
// result and the output does not stall; else the output serializer sets the
// rate. A result passes the decoder batch register and then the output
// register; input is still taken while a result waits if no batch is pending.
module utf8_whitespace_tokenizer (
  input  logic       clk,
  input  logic       rst_n,
  uwt_in_if.sink     in_chan,
  uwt_out_if.source  out_chan
);

  logic                batch_v;
  logic                batch_take;
  uwt_pkg::uwt_batch_t batch;

  uwt_decode u_decode (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .batch_v    (batch_v),
    .batch      (batch),
    .batch_take (batch_take)
  );

  uwt_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .batch_v    (batch_v),
    .batch      (batch),
    .batch_take (batch_take),
    .out_chan   (out_chan)
  );

endmodule
